### design/csa_pkg.sv
package csa_pkg;

    // Field and fixed-point geometry.
    localparam int FIELD_W    = 20;
    localparam int LIMIT_W    = 19;
    localparam int FRAC_BITS  = 12;
    localparam int SIG_DEPTH  = 256;
    localparam int KW         = $clog2(SIG_DEPTH);
    localparam int XW         = FRAC_BITS + 4;
    localparam int T_W        = XW + KW;
    localparam int SIG_W      = 17;
    localparam int ACC_W      = SIG_W + XW + 2;
    localparam int GS_W       = 36;
    localparam int P_W        = 56;
    localparam int MAG_W      = 55;
    localparam int ROUND_SH   = FRAC_BITS + 16;
    localparam int NUM_STAGES = 8;

    localparam int GATE_HI    = 8 << FRAC_BITS;
    localparam int GATE_LO    = -GATE_HI;
    localparam int INTERP_HALF = 1 << (XW - 1);
    localparam int OUT_MAX    = 524287;
    localparam int OUT_MIN    = -524288;

    localparam longint KNOT_DEN = 16 * SIG_DEPTH;
    localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF = 64'd1 << 29;

    typedef logic signed [FIELD_W-1:0] field_t;
    typedef logic [LIMIT_W-1:0]        limit_t;
    typedef logic [SIG_W-1:0]          sig_t;
    typedef logic [KW-1:0]             k_t;
    typedef logic [XW-1:0]             frac_t;
    typedef logic signed [GS_W-1:0]    gs_t;
    typedef logic signed [P_W-1:0]     prod_t;
    typedef logic [MAG_W-1:0]          mag_t;

    localparam limit_t LIMIT_RESET = 19'd28672;
    localparam sig_t   SIG_ONE     = sig_t'(1 << 16);
    localparam mag_t   ROUND_BIAS  = mag_t'(1) << (ROUND_SH - 1);

    // Clamped operands and table address, out of the front stages.
    typedef struct packed {
        field_t gc;
        field_t uc;
        logic   below;
        logic   above;
        k_t     k;
        frac_t  f;
    } idx_t;

    // Clamped operands with the interpolated sigmoid.
    typedef struct packed {
        field_t gc;
        field_t uc;
        sig_t   sig;
    } sig_stage_t;

    typedef sig_t sig_tab_t [SIG_DEPTH];

    // Shift-and-subtract divide, used only while the tables are built.
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // One knot of the sigmoid in Q0.16: e^-|x| by a Taylor series on |x|/16,
    // squared four times, then 1/(1+E) or E/(1+E).
    function automatic sig_t knot_sig(int k);
        longint      diff;
        longint      sum;
        logic [63:0] num;
        logic [63:0] r;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] den2;
        logic [63:0] q;
        diff = 16 * longint'(k) - 8 * longint'(SIG_DEPTH);
        num  = (diff < 0) ? 64'(-diff) : 64'(diff);
        r    = ((num << 30) + 64'(KNOT_DEN / 2)) / KNOT_DEN;
        term = Q30_ONE;
        sum  = longint'(Q30_ONE);
        for (int n = 1; n <= 12; n++)
        begin
            term = (term * r + Q30_HALF) >> 30;
            term = udiv64(term + 64'(n >> 1), 64'(n));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        e = 64'(sum);
        for (int n = 0; n < 4; n++)
            e = (e * e + Q30_HALF) >> 30;
        den2 = Q30_ONE + e;
        if (diff >= 0)
            q = udiv64((Q30_ONE << 16) + (den2 >> 1), den2);
        else
            q = udiv64((e << 16) + (den2 >> 1), den2);
        return SIG_W'(q);
    endfunction

    function automatic sig_tab_t build_sig_tab(int offset);
        sig_tab_t tab;
        for (int k = 0; k < SIG_DEPTH; k++)
            tab[k] = knot_sig(k + offset);
        return tab;
    endfunction

    // Left and right knot of every interval, so each is read once per cycle.
    localparam sig_tab_t SIG_LO_TAB = build_sig_tab(0);
    localparam sig_tab_t SIG_HI_TAB = build_sig_tab(1);

endpackage

### design/csa_ifs.sv
interface csa_in_if;
    import csa_pkg::*;
    logic   valid;
    logic   ready;
    field_t gate_value;
    field_t up_value;
    modport source (output valid, output gate_value, output up_value, input ready);
    modport sink (input valid, input gate_value, input up_value, output ready);
endinterface

interface csa_out_if;
    import csa_pkg::*;
    logic   valid;
    logic   ready;
    field_t activated_value;
    modport source (output valid, output activated_value, input ready);
    modport sink (input valid, input activated_value, output ready);
endinterface

interface csa_cfg_if;
    import csa_pkg::*;
    logic   valid;
    logic   ready;
    limit_t clamp_limit;
    modport source (output valid, output clamp_limit, input ready);
    modport sink (input valid, input clamp_limit, output ready);
endinterface

### design/csa_clamp.sv
module csa_clamp (
    input  logic            clk,
    input  logic [1:0]      load,
    input  csa_pkg::field_t gate,
    input  csa_pkg::field_t up,
    input  csa_pkg::limit_t limit,
    output csa_pkg::idx_t   idx
);
    import csa_pkg::*;

    logic signed [FIELD_W:0] lim_pos;
    logic signed [FIELD_W:0] lim_neg;
    field_t                  gc_next;
    field_t                  uc_next;
    field_t                  gc_reg;
    field_t                  uc_reg;
    frac_t                   xoff;
    logic [T_W-1:0]          t;
    idx_t                    idx_next;
    idx_t                    idx_reg;

    // Stage one: clamp up on both sides and gate from above.
    always_comb
    begin
        lim_pos = signed'({2'b00, limit});
        lim_neg = -lim_pos;
        uc_next = up;
        if (up > lim_pos)
            uc_next = FIELD_W'(lim_pos);
        else if (up < lim_neg)
            uc_next = FIELD_W'(lim_neg);
        gc_next = gate;
        if (!(gate < lim_pos))
            gc_next = FIELD_W'(lim_pos);
    end

    // Stage two: offset the gate into the table span and split it into
    // knot index and interpolation fraction.
    always_comb
    begin
        xoff           = XW'(gc_reg) + XW'(GATE_HI);
        t              = T_W'(xoff) * T_W'(SIG_DEPTH);
        idx_next.gc    = gc_reg;
        idx_next.uc    = uc_reg;
        idx_next.below = gc_reg < GATE_LO;
        idx_next.above = gc_reg >= GATE_HI;
        idx_next.k     = t[T_W-1:XW];
        idx_next.f     = t[XW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            gc_reg <= gc_next;
            uc_reg <= uc_next;
        end
        if (load[1])
            idx_reg <= idx_next;
    end

    assign idx = idx_reg;

endmodule

### design/csa_sigmoid.sv
module csa_sigmoid (
    input  logic                clk,
    input  logic [1:0]          load,
    input  csa_pkg::idx_t       idx,
    output csa_pkg::sig_stage_t sig
);
    import csa_pkg::*;

    sig_t                        base_next;
    logic signed [SIG_W:0]       delta_next;
    field_t                      gc_reg;
    field_t                      uc_reg;
    logic                        below_reg;
    logic                        above_reg;
    sig_t                        base_reg;
    logic signed [SIG_W:0]       delta_reg;
    frac_t                       f_reg;
    logic signed [ACC_W-1:0]     slope;
    logic signed [ACC_W-1:0]     acc_lin;
    logic signed [ACC_W-1:0]     acc;
    sig_t                        sig_interp;
    sig_stage_t                  sig_next;
    sig_stage_t                  sig_reg;

    // Stage three: read both knots of the interval.
    always_comb
    begin
        base_next  = SIG_LO_TAB[idx.k];
        delta_next = signed'({1'b0, SIG_HI_TAB[idx.k]}) - signed'({1'b0, base_next});
    end

    // Stage four: base*W + (next-base)*f, rounded back to Q0.16.
    always_comb
    begin
        slope      = delta_reg * signed'({1'b0, f_reg});
        acc_lin    = signed'({2'b00, base_reg, {XW{1'b0}}});
        acc        = acc_lin + slope + ACC_W'(INTERP_HALF);
        sig_interp = acc[XW+SIG_W-1:XW];
        sig_next.gc = gc_reg;
        sig_next.uc = uc_reg;
        if (below_reg)
            sig_next.sig = '0;
        else if (above_reg)
            sig_next.sig = SIG_ONE;
        else
            sig_next.sig = sig_interp;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            gc_reg    <= idx.gc;
            uc_reg    <= idx.uc;
            below_reg <= idx.below;
            above_reg <= idx.above;
            base_reg  <= base_next;
            delta_reg <= delta_next;
            f_reg     <= idx.f;
        end
        if (load[1])
            sig_reg <= sig_next;
    end

    assign sig = sig_reg;

endmodule

### design/csa_mult.sv
module csa_mult (
    input  logic                clk,
    input  logic [3:0]          load,
    input  csa_pkg::sig_stage_t sig,
    output csa_pkg::field_t     activated
);
    import csa_pkg::*;

    logic signed [FIELD_W+SIG_W:0] gs_full;
    gs_t                           gs_reg;
    field_t                        uc_reg;
    prod_t                         p_next;
    prod_t                         p_reg;
    logic [P_W-1:0]                p_sel;
    logic                          neg_next;
    mag_t                          mag_next;
    logic                          neg_reg;
    mag_t                          mag_reg;
    mag_t                          q;
    field_t                        act_next;
    field_t                        act_reg;

    // gate * sigmoid stays below 2^35 in magnitude, so 36 bits hold it.
    assign gs_full = sig.gc * signed'({1'b0, sig.sig});
    assign p_next  = gs_reg * uc_reg;

    // Half away from zero: for a negative product, |p| + bias is ~p + 1 + bias.
    always_comb
    begin
        neg_next = p_reg[P_W-1];
        p_sel    = neg_next ? ~p_reg : p_reg;
        mag_next = p_sel[MAG_W-1:0] + ROUND_BIAS + mag_t'(neg_next);
    end

    always_comb
    begin
        q = mag_reg >> ROUND_SH;
        if (neg_reg)
        begin
            if (q > mag_t'(-OUT_MIN))
                act_next = field_t'(OUT_MIN);
            else
                act_next = field_t'(0 - q[FIELD_W-1:0]);
        end
        else
        begin
            if (q > mag_t'(OUT_MAX))
                act_next = field_t'(OUT_MAX);
            else
                act_next = field_t'(q[FIELD_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            gs_reg <= GS_W'(gs_full);
            uc_reg <= sig.uc;
        end
        if (load[1])
            p_reg <= p_next;
        if (load[2])
        begin
            neg_reg <= neg_next;
            mag_reg <= mag_next;
        end
        if (load[3])
            act_reg <= act_next;
    end

    assign activated = act_reg;

endmodule

### design/clamped_swiglu_activation_core.sv
// Pipeline: eight register stages; a word accepted into the first stage is
// offered on the result channel from the last one, when no stage is stalled.
// Throughput: one word per cycle; each stage moves when its successor frees.
// Reset clears every stage's valid bit and sets the clamp limit to 7.0.
// The sigmoid knots are constant tables, so no fill pass follows reset.
module clamped_swiglu_activation_core (
    input logic       clk,
    input logic       rst_n,
    csa_cfg_if.sink   cfg,
    csa_in_if.sink    operand,
    csa_out_if.source result
);
    import csa_pkg::*;

    limit_t                limit_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] take;
    idx_t                  idx_stage;
    sig_stage_t            sig_stage;
    field_t                activated;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg.valid)
            limit_reg <= cfg.clamp_limit;
    end

    // A stage takes a new word when it is empty or its word moves on, so
    // bubbles close up while the result waits.
    always_comb
    begin
        take[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || result.ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
            take[i] = !valid_reg[i] || take[i+1];
        valid_next = valid_reg;
        if (take[0])
            valid_next[0] = operand.valid;
        for (int i = 1; i < NUM_STAGES; i++)
            if (take[i])
                valid_next[i] = valid_reg[i-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    csa_clamp u_clamp (
        .clk   (clk),
        .load  (take[1:0]),
        .gate  (operand.gate_value),
        .up    (operand.up_value),
        .limit (limit_reg),
        .idx   (idx_stage)
    );

    csa_sigmoid u_sigmoid (
        .clk  (clk),
        .load (take[3:2]),
        .idx  (idx_stage),
        .sig  (sig_stage)
    );

    csa_mult u_mult (
        .clk       (clk),
        .load      (take[7:4]),
        .sig       (sig_stage),
        .activated (activated)
    );

    assign operand.ready          = take[0];
    assign result.valid           = valid_reg[NUM_STAGES-1];
    assign result.activated_value = activated;

    a_blocked_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !operand.ready |-> (&valid_reg))
        else $error("input stalled while a pipeline stage was empty");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        operand.valid && operand.ready |=> valid_reg[0])
        else $error("accepted word did not enter the first stage");

    a_sig_at_most_one: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] |-> (sig_stage.sig <= SIG_ONE))
        else $error("interpolated sigmoid above one");

    a_sig_zero_below: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] && (sig_stage.gc < GATE_LO) |-> (sig_stage.sig == '0))
        else $error("sigmoid not zero below the table span");

endmodule
